@@ src/lbaa_pkg.sv @@
// Package with the command, status and selection codes of the bus addressing block.
`timescale 1ns / 1ps
package lbaa_pkg;

  localparam int unsigned AddrW  = 24;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LimitW = 7;

  localparam logic [AddrW-1:0] AddrOnes = 24'hFF_FFFF;
  localparam logic [ByteW-1:0] ByteOnes = 8'hFF;

  localparam logic [3:0] CmdTick      = 4'd0;
  localparam logic [3:0] CmdInit      = 4'd1;
  localparam logic [3:0] CmdRandomise = 4'd2;
  localparam logic [3:0] CmdCompare   = 4'd3;
  localparam logic [3:0] CmdWithdraw  = 4'd4;
  localparam logic [3:0] CmdSearchHi  = 4'd5;
  localparam logic [3:0] CmdSearchMid = 4'd6;
  localparam logic [3:0] CmdSearchLo  = 4'd7;
  localparam logic [3:0] CmdProgram   = 4'd8;
  localparam logic [3:0] CmdVerify    = 4'd9;
  localparam logic [3:0] CmdQuery     = 4'd10;
  localparam logic [3:0] CmdPhysSel   = 4'd11;
  localparam logic [3:0] CmdTerminate = 4'd12;
  localparam logic [3:0] CmdReset     = 4'd13;
  localparam logic [3:0] CmdLampOff   = 4'd14;
  localparam logic [3:0] CmdLampOk    = 4'd15;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNo       = 3'd1;
  localparam logic [2:0] StBadState = 3'd2;
  localparam logic [2:0] StError    = 3'd3;
  localparam logic [2:0] StNone     = 3'd4;

  localparam logic [1:0] SelNone     = 2'd0;
  localparam logic [1:0] SelSelected = 2'd1;
  localparam logic [1:0] SelPhysical = 2'd2;
  localparam logic [1:0] SelUnused   = 2'd3;

  localparam logic       CfgTimeout = 1'b0;
  localparam logic       CfgLimit   = 1'b1;

endpackage

@@ src/lighting_bus_address_assignment.sv @@
// Slave-side random address search session of a lighting control bus.
// Result: an accepted request's status and the new state are registered at the edge that accepts it.
// Throughput: one request per cycle while results are taken; a held result stalls new requests.
// Reset: asynchronous, active low; session closed, addresses all ones,
// short address 0xFF, timeout 900000 ms, short address limit 63.
`timescale 1ns / 1ps
module lighting_bus_address_assignment (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  command_i,
  input  logic [7:0]  data_byte_i,
  input  logic [23:0] random_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  short_addr_out_o,
  output logic        session_active_o,
  output logic [1:0]  selection_mode_o
);

  logic [lbaa_pkg::AddrW-1:0]  timeout_q;
  logic [lbaa_pkg::LimitW-1:0] limit_q;

  logic                        init_q, init_d;
  logic                        wd_q, wd_d;
  logic [1:0]                  sel_q, sel_d;
  logic [lbaa_pkg::AddrW-1:0]  search_q, search_d;
  logic [lbaa_pkg::AddrW-1:0]  rand_q, rand_d;
  logic [lbaa_pkg::ByteW-1:0]  short_q, short_d;
  logic [lbaa_pkg::AddrW-1:0]  elapsed_q, elapsed_d;

  logic                        out_valid_q;
  logic [2:0]                  status_q, status_d;

  logic                        accept;
  logic [lbaa_pkg::AddrW-1:0]  el_tick;
  logic                        chk;
  logic                        expire;
  logic                        init1, wd1;
  logic [1:0]                  sel1;
  logic [lbaa_pkg::AddrW-1:0]  el1;
  logic                        normal_sel;
  logic                        match;
  logic                        bad_addr;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    el_tick = elapsed_q;
    if (command_i == lbaa_pkg::CmdTick && init_q && elapsed_q != lbaa_pkg::AddrOnes) begin
      el_tick = elapsed_q + 24'd1;
    end
    chk = (command_i != lbaa_pkg::CmdTerminate) && (command_i != lbaa_pkg::CmdLampOff) &&
          (command_i != lbaa_pkg::CmdLampOk);
    expire = chk && init_q && (el_tick > timeout_q);
    init1  = expire ? 1'b0 : init_q;
    wd1    = expire ? 1'b0 : wd_q;
    sel1   = expire ? lbaa_pkg::SelNone : sel_q;
    el1    = expire ? '0 : el_tick;
  end

  assign normal_sel = (sel1 == lbaa_pkg::SelNone) || (sel1 == lbaa_pkg::SelSelected);
  assign match      = (search_q == rand_q);
  assign bad_addr   = (data_byte_i != lbaa_pkg::ByteOnes) &&
                      (data_byte_i[7:1] > limit_q);

  always_comb begin
    init_d    = init1;
    wd_d      = wd1;
    sel_d     = sel1;
    elapsed_d = el1;
    search_d  = search_q;
    rand_d    = rand_q;
    short_d   = short_q;
    status_d  = lbaa_pkg::StNone;
    case (command_i)
      lbaa_pkg::CmdInit: begin
        if (!init1) begin
          init_d    = 1'b1;
          elapsed_d = '0;
          status_d  = lbaa_pkg::StOk;
        end else begin
          status_d  = lbaa_pkg::StBadState;
        end
      end
      lbaa_pkg::CmdRandomise: begin
        rand_d   = random_value_i;
        status_d = lbaa_pkg::StOk;
      end
      lbaa_pkg::CmdCompare: begin
        if (!init1 || !normal_sel) begin
          status_d = lbaa_pkg::StBadState;
        end else if (wd1) begin
          status_d = lbaa_pkg::StNo;
        end else begin
          status_d = (rand_q <= search_q) ? lbaa_pkg::StOk : lbaa_pkg::StNo;
        end
      end
      lbaa_pkg::CmdWithdraw: begin
        if (!init1 || !normal_sel) begin
          status_d = lbaa_pkg::StBadState;
        end else begin
          if (match) begin
            wd_d = 1'b1;
          end
          status_d = lbaa_pkg::StOk;
        end
      end
      lbaa_pkg::CmdSearchHi: begin
        if (init1) begin
          search_d[23:16] = data_byte_i;
          status_d        = lbaa_pkg::StOk;
        end else begin
          status_d        = lbaa_pkg::StBadState;
        end
      end
      lbaa_pkg::CmdSearchMid: begin
        if (init1) begin
          search_d[15:8] = data_byte_i;
          status_d       = lbaa_pkg::StOk;
        end else begin
          status_d       = lbaa_pkg::StBadState;
        end
      end
      lbaa_pkg::CmdSearchLo: begin
        if (init1) begin
          search_d[7:0] = data_byte_i;
          status_d      = lbaa_pkg::StOk;
        end else begin
          status_d      = lbaa_pkg::StBadState;
        end
      end
      lbaa_pkg::CmdProgram: begin
        if (bad_addr) begin
          status_d = lbaa_pkg::StError;
        end else if (!init1) begin
          status_d = lbaa_pkg::StBadState;
        end else if (normal_sel) begin
          if (match) begin
            short_d = data_byte_i;
          end
          status_d = lbaa_pkg::StOk;
        end else if (sel1 == lbaa_pkg::SelPhysical) begin
          short_d  = data_byte_i;
          status_d = lbaa_pkg::StOk;
        end else begin
          status_d = lbaa_pkg::StBadState;
        end
      end
      lbaa_pkg::CmdVerify: begin
        if (init1) begin
          status_d = (short_q == data_byte_i) ? lbaa_pkg::StOk : lbaa_pkg::StNo;
        end else begin
          status_d = lbaa_pkg::StBadState;
        end
      end
      lbaa_pkg::CmdQuery: begin
        if (!init1) begin
          status_d = lbaa_pkg::StBadState;
        end else if (normal_sel) begin
          status_d = match ? lbaa_pkg::StOk : lbaa_pkg::StNo;
        end else if (sel1 == lbaa_pkg::SelPhysical) begin
          status_d = lbaa_pkg::StOk;
        end else begin
          status_d = lbaa_pkg::StBadState;
        end
      end
      lbaa_pkg::CmdPhysSel: begin
        if (init1) begin
          sel_d    = (sel1 == lbaa_pkg::SelSelected) ? lbaa_pkg::SelNone
                                                     : lbaa_pkg::SelSelected;
          status_d = lbaa_pkg::StOk;
        end else begin
          status_d = lbaa_pkg::StBadState;
        end
      end
      lbaa_pkg::CmdTerminate: begin
        if (init1) begin
          init_d    = 1'b0;
          wd_d      = 1'b0;
          sel_d     = lbaa_pkg::SelNone;
          elapsed_d = '0;
          status_d  = lbaa_pkg::StOk;
        end else begin
          status_d  = lbaa_pkg::StBadState;
        end
      end
      lbaa_pkg::CmdReset: begin
        sel_d = lbaa_pkg::SelNone;
        wd_d  = 1'b0;
      end
      lbaa_pkg::CmdLampOff: begin
        if (sel1 == lbaa_pkg::SelSelected) begin
          sel_d = lbaa_pkg::SelPhysical;
        end
      end
      lbaa_pkg::CmdLampOk: begin
        if (sel1 == lbaa_pkg::SelPhysical) begin
          sel_d = lbaa_pkg::SelSelected;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= 24'd900000;
      limit_q   <= 7'd63;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lbaa_pkg::CfgTimeout: timeout_q <= cfg_data_i;
        lbaa_pkg::CfgLimit:   limit_q   <= cfg_data_i[lbaa_pkg::LimitW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q    <= 1'b0;
      wd_q      <= 1'b0;
      sel_q     <= lbaa_pkg::SelNone;
      search_q  <= lbaa_pkg::AddrOnes;
      rand_q    <= lbaa_pkg::AddrOnes;
      short_q   <= lbaa_pkg::ByteOnes;
      elapsed_q <= '0;
    end else if (accept) begin
      init_q    <= init_d;
      wd_q      <= wd_d;
      sel_q     <= sel_d;
      search_q  <= search_d;
      rand_q    <= rand_d;
      short_q   <= short_d;
      elapsed_q <= elapsed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign short_addr_out_o = short_q;
  assign session_active_o = init_q;
  assign selection_mode_o = sel_q;

  a_idle_counter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_q |-> elapsed_q == '0)
    else $error("elapsed counter running outside a session");

  a_idle_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_q |-> (!wd_q && sel_q == lbaa_pkg::SelNone))
    else $error("withdraw or selection held outside a session");

  a_sel_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q != lbaa_pkg::SelUnused)
    else $error("unused selection code reached");

  a_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted request produced no result");

endmodule

@@ test/lighting_bus_address_assignment_tb.sv @@
// Self-checking testbench for the bus address assignment block: directed and random sessions.
`timescale 1ns / 1ps
module lighting_bus_address_assignment_tb;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned ItemsPerSetting = 390;
  localparam int unsigned HoldOffCycles = 300;

  typedef struct packed {
    logic [3:0]                 cmd;
    logic [2:0]                 status;
    logic [lbaa_pkg::ByteW-1:0] short_addr;
    logic                       active;
    logic [1:0]                 sel;
  } addr_result_t;

  class addr_session_scoreboard;
    logic [lbaa_pkg::AddrW-1:0]  timeout_ticks;
    logic [lbaa_pkg::LimitW-1:0] addr_limit;
    bit                          in_session;
    bit                          is_withdrawn;
    logic [1:0]                  sel;
    logic [lbaa_pkg::AddrW-1:0]  search_addr, rand_addr, elapsed;
    logic [lbaa_pkg::ByteW-1:0]  short_addr;
    addr_result_t                expected_q[$];
    int errors, requests, results, timeouts, withdrawals, stores;

    function new();
      timeout_ticks = 24'd900000;
      addr_limit = 7'd63;
      in_session = 1'b0;
      is_withdrawn = 1'b0;
      sel = lbaa_pkg::SelNone;
      search_addr = lbaa_pkg::AddrOnes;
      rand_addr = lbaa_pkg::AddrOnes;
      short_addr = lbaa_pkg::ByteOnes;
      elapsed = '0;
      errors = 0;
      requests = 0;
      results = 0;
      timeouts = 0;
      withdrawals = 0;
      stores = 0;
    endfunction

    function void set_reg(input logic idx, input logic [lbaa_pkg::AddrW-1:0] val);
      if (idx == lbaa_pkg::CfgTimeout) timeout_ticks = val;
      else addr_limit = val[lbaa_pkg::LimitW-1:0];
    endfunction

    function void end_session();
      in_session = 1'b0;
      is_withdrawn = 1'b0;
      sel = lbaa_pkg::SelNone;
      elapsed = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(input string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function void note_request(input logic [3:0] cmd, input logic [lbaa_pkg::ByteW-1:0] db,
                               input logic [lbaa_pkg::AddrW-1:0] rv);
      logic [2:0] st;
      bit normal_sel;
      bit addr_match;
      st = lbaa_pkg::StNone;
      if (cmd == lbaa_pkg::CmdTick && in_session && elapsed != lbaa_pkg::AddrOnes) elapsed++;
      if (cmd != lbaa_pkg::CmdTerminate && cmd != lbaa_pkg::CmdLampOff &&
          cmd != lbaa_pkg::CmdLampOk && in_session && elapsed > timeout_ticks) begin
        end_session();
        timeouts++;
      end
      normal_sel = (sel == lbaa_pkg::SelNone || sel == lbaa_pkg::SelSelected);
      addr_match = (search_addr == rand_addr);
      case (cmd)
        lbaa_pkg::CmdInit: begin
          if (!in_session) begin
            in_session = 1'b1;
            elapsed = '0;
            st = lbaa_pkg::StOk;
          end else st = lbaa_pkg::StBadState;
        end
        lbaa_pkg::CmdRandomise: begin
          rand_addr = rv;
          st = lbaa_pkg::StOk;
        end
        lbaa_pkg::CmdCompare: begin
          if (!in_session || !normal_sel) st = lbaa_pkg::StBadState;
          else if (is_withdrawn) st = lbaa_pkg::StNo;
          else st = (rand_addr <= search_addr) ? lbaa_pkg::StOk : lbaa_pkg::StNo;
        end
        lbaa_pkg::CmdWithdraw: begin
          if (!in_session || !normal_sel) st = lbaa_pkg::StBadState;
          else begin
            if (addr_match) begin
              if (!is_withdrawn) withdrawals++;
              is_withdrawn = 1'b1;
            end
            st = lbaa_pkg::StOk;
          end
        end
        lbaa_pkg::CmdSearchHi, lbaa_pkg::CmdSearchMid, lbaa_pkg::CmdSearchLo: begin
          if (in_session) begin
            if (cmd == lbaa_pkg::CmdSearchHi) search_addr[23:16] = db;
            else if (cmd == lbaa_pkg::CmdSearchMid) search_addr[15:8] = db;
            else search_addr[7:0] = db;
            st = lbaa_pkg::StOk;
          end else st = lbaa_pkg::StBadState;
        end
        lbaa_pkg::CmdProgram: begin
          if (db != lbaa_pkg::ByteOnes && (db >> 1) > addr_limit) st = lbaa_pkg::StError;
          else if (!in_session) st = lbaa_pkg::StBadState;
          else if (normal_sel) begin
            if (addr_match) begin
              short_addr = db;
              stores++;
            end
            st = lbaa_pkg::StOk;
          end else if (sel == lbaa_pkg::SelPhysical) begin
            short_addr = db;
            stores++;
            st = lbaa_pkg::StOk;
          end else st = lbaa_pkg::StBadState;
        end
        lbaa_pkg::CmdVerify: begin
          if (in_session) st = (short_addr == db) ? lbaa_pkg::StOk : lbaa_pkg::StNo;
          else st = lbaa_pkg::StBadState;
        end
        lbaa_pkg::CmdQuery: begin
          if (!in_session) st = lbaa_pkg::StBadState;
          else if (normal_sel) st = addr_match ? lbaa_pkg::StOk : lbaa_pkg::StNo;
          else if (sel == lbaa_pkg::SelPhysical) st = lbaa_pkg::StOk;
          else st = lbaa_pkg::StBadState;
        end
        lbaa_pkg::CmdPhysSel: begin
          if (in_session) begin
            sel = (sel == lbaa_pkg::SelSelected) ? lbaa_pkg::SelNone : lbaa_pkg::SelSelected;
            st = lbaa_pkg::StOk;
          end else st = lbaa_pkg::StBadState;
        end
        lbaa_pkg::CmdTerminate: begin
          if (in_session) begin
            end_session();
            st = lbaa_pkg::StOk;
          end else st = lbaa_pkg::StBadState;
        end
        lbaa_pkg::CmdReset: begin
          sel = lbaa_pkg::SelNone;
          is_withdrawn = 1'b0;
        end
        lbaa_pkg::CmdLampOff: if (sel == lbaa_pkg::SelSelected) sel = lbaa_pkg::SelPhysical;
        lbaa_pkg::CmdLampOk: if (sel == lbaa_pkg::SelPhysical) sel = lbaa_pkg::SelSelected;
        default: ;
      endcase
      expected_q.push_back('{cmd, st, short_addr, in_session, sel});
      requests++;
    endfunction

    task check_result(input logic [2:0] status, input logic [lbaa_pkg::ByteW-1:0] sa,
                      input logic active, input logic [1:0] sm);
      addr_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
        return;
      end
      want = expected_q.pop_front();
      results++;
      if (status !== want.status)
        report_mismatch($sformatf("result %0d (cmd %0d): status %0d, want %0d",
                                  results, want.cmd, status, want.status));
      if (sa !== want.short_addr)
        report_mismatch($sformatf("result %0d (cmd %0d): short addr %0h, want %0h",
                                  results, want.cmd, sa, want.short_addr));
      if (active !== want.active)
        report_mismatch($sformatf("result %0d (cmd %0d): session %0b, want %0b",
                                  results, want.cmd, active, want.active));
      if (sm !== want.sel)
        report_mismatch($sformatf("result %0d (cmd %0d): selection %0d, want %0d",
                                  results, want.cmd, sm, want.sel));
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_index_i;
  logic [23:0]      cfg_data_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [3:0]       command_i;
  logic [7:0]       data_byte_i;
  logic [23:0]      random_value_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [2:0]       status_o;
  logic [7:0]       short_addr_out_o;
  logic             session_active_o;
  logic [1:0]       selection_mode_o;

  addr_session_scoreboard sb;
  bit offering;
  bit no_idle;
  bit hold_off_req;
  int settings;

  lighting_bus_address_assignment dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .data_byte_i      (data_byte_i),
    .random_value_i   (random_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .short_addr_out_o (short_addr_out_o),
    .session_active_o (session_active_o),
    .selection_mode_o (selection_mode_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(input logic [3:0] cmd, input logic [7:0] db,
                              input logic [23:0] rv);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      if (offering) in_valid_i <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    data_byte_i <= db;
    random_value_i <= rv;
    offering = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(cmd, db, rv);
  endtask

  task automatic drain_results();
    if (offering) in_valid_i <= 1'b0;
    offering = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [23:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    sb.set_reg(idx, val);
  endtask

  task automatic apply_setting(input logic [23:0] tmo, input logic [6:0] lim);
    drain_results();
    write_reg(lbaa_pkg::CfgTimeout, tmo);
    write_reg(lbaa_pkg::CfgLimit, {17'd0, lim});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic random_request();
    logic [3:0] cmd;
    logic [7:0] db;
    logic [23:0] rv;
    int r;
    cmd = 4'($urandom_range(0, 15));
    db = 8'($urandom);
    rv = 24'($urandom);
    r = $urandom_range(0, 99);
    if (r >= 10) begin
      if (!sb.in_session) begin
        if (r < 55) cmd = lbaa_pkg::CmdInit;
        else if (r < 65) cmd = lbaa_pkg::CmdRandomise;
        else if (r < 75) cmd = lbaa_pkg::CmdTick;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 12) cmd = lbaa_pkg::CmdTick;
        else if (r < 18) cmd = lbaa_pkg::CmdRandomise;
        else if (r < 33) begin
          case ($urandom_range(0, 2))
            0: cmd = lbaa_pkg::CmdSearchHi;
            1: cmd = lbaa_pkg::CmdSearchMid;
            default: cmd = lbaa_pkg::CmdSearchLo;
          endcase
        end
        else if (r < 43) cmd = lbaa_pkg::CmdCompare;
        else if (r < 49) cmd = lbaa_pkg::CmdWithdraw;
        else if (r < 58) cmd = lbaa_pkg::CmdProgram;
        else if (r < 64) cmd = lbaa_pkg::CmdVerify;
        else if (r < 72) cmd = lbaa_pkg::CmdQuery;
        else if (r < 77) cmd = lbaa_pkg::CmdPhysSel;
        else if (r < 82) cmd = lbaa_pkg::CmdLampOff;
        else if (r < 86) cmd = lbaa_pkg::CmdLampOk;
        else if (r < 90) cmd = lbaa_pkg::CmdReset;
        else if (r < 94) cmd = lbaa_pkg::CmdTerminate;
        else cmd = lbaa_pkg::CmdInit;
      end
    end
    r = $urandom_range(0, 9);
    case (cmd)
      lbaa_pkg::CmdSearchHi: if (r < 7) db = sb.rand_addr[23:16];
      lbaa_pkg::CmdSearchMid: if (r < 7) db = sb.rand_addr[15:8];
      lbaa_pkg::CmdSearchLo: if (r < 7) db = sb.rand_addr[7:0];
      lbaa_pkg::CmdRandomise: begin
        if (r == 0) rv = '0;
        else if (r == 1) rv = lbaa_pkg::AddrOnes;
        else if (r == 2) rv = sb.search_addr;
      end
      lbaa_pkg::CmdProgram: begin
        if (r < 4) db[7:1] = 7'($urandom_range(0, sb.addr_limit));
        else if (r == 4) db = lbaa_pkg::ByteOnes;
        else if (r < 7 && sb.addr_limit != 7'h7F) db[7:1] = sb.addr_limit + 7'd1;
      end
      lbaa_pkg::CmdVerify: if (r < 5) db = sb.short_addr;
      default: ;
    endcase
    send_request(cmd, db, rv);
  endtask

  task automatic run_random(input int count, input int pause_at, input int hold_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_off_req = 1'b1;
      if (i == pause_at) drain_results();
      random_request();
    end
  endtask

  initial begin
    int run_len;
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      run_len = no_idle ? 40 : $urandom_range(1, 24);
      repeat (run_len) @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HoldOffCycles;
      end else stall = pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(status_o, short_addr_out_o, session_active_o, selection_mode_o);
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("Run stopped at the cycle limit of %0d", CycleLimit);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    sb = new();
    offering = 1'b0;
    no_idle = 1'b0;
    hold_off_req = 1'b0;
    settings = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = lbaa_pkg::CfgTimeout;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    command_i = lbaa_pkg::CmdTick;
    data_byte_i = '0;
    random_value_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(lbaa_pkg::CmdTick, 8'h00, 24'h000000);
    send_request(lbaa_pkg::CmdProgram, 8'h80, 24'h000000);
    send_request(lbaa_pkg::CmdProgram, 8'h7E, 24'hFFFFFF);
    send_request(lbaa_pkg::CmdRandomise, 8'h00, 24'h123456);
    send_request(lbaa_pkg::CmdInit, 8'hFF, 24'h000000);
    send_request(lbaa_pkg::CmdInit, 8'h00, 24'hFFFFFF);
    send_request(lbaa_pkg::CmdSearchHi, 8'h12, 24'h000000);
    send_request(lbaa_pkg::CmdSearchMid, 8'h34, 24'hFFFFFF);
    send_request(lbaa_pkg::CmdSearchLo, 8'h56, 24'h000000);
    send_request(lbaa_pkg::CmdCompare, 8'h00, 24'h000000);
    send_request(lbaa_pkg::CmdQuery, 8'h00, 24'h000000);
    send_request(lbaa_pkg::CmdProgram, 8'h7F, 24'h000000);
    send_request(lbaa_pkg::CmdVerify, 8'h7F, 24'h000000);
    send_request(lbaa_pkg::CmdSearchLo, 8'h55, 24'h000000);
    send_request(lbaa_pkg::CmdWithdraw, 8'h00, 24'h000000);
    send_request(lbaa_pkg::CmdSearchLo, 8'h56, 24'h000000);
    send_request(lbaa_pkg::CmdWithdraw, 8'h00, 24'h000000);
    send_request(lbaa_pkg::CmdCompare, 8'h00, 24'h000000);
    send_request(lbaa_pkg::CmdPhysSel, 8'h00, 24'h000000);
    send_request(lbaa_pkg::CmdLampOff, 8'h00, 24'h000000);
    send_request(lbaa_pkg::CmdProgram, 8'hFF, 24'h000000);
    send_request(lbaa_pkg::CmdQuery, 8'h00, 24'h000000);
    send_request(lbaa_pkg::CmdLampOk, 8'h00, 24'h000000);
    send_request(lbaa_pkg::CmdReset, 8'h00, 24'h000000);
    send_request(lbaa_pkg::CmdTerminate, 8'h00, 24'h000000);
    send_request(lbaa_pkg::CmdTerminate, 8'h00, 24'h000000);

    apply_setting(24'd1, 7'd0);
    run_random(ItemsPerSetting, -1, -1);
    apply_setting(24'd6, 7'd127);
    run_random(ItemsPerSetting, -1, 100);
    apply_setting(lbaa_pkg::AddrOnes, 7'd63);
    run_random(ItemsPerSetting, 200, -1);
    apply_setting(24'($urandom_range(2, 40)), 7'($urandom_range(1, 126)));
    no_idle = 1'b1;
    run_random(150, -1, -1);
    no_idle = 1'b0;
    run_random(ItemsPerSetting - 150, -1, -1);
    apply_setting(24'd900000, 7'($urandom_range(0, 127)));
    run_random(ItemsPerSetting, -1, -1);

    drain_results();
    repeat (4) @(posedge clk_i);
    $display("Sent %0d requests and checked %0d results across reset values and %0d settings.",
             sb.requests, sb.results, settings);
    $display("Seen %0d session timeouts, %0d withdrawals, %0d short address stores; %0d mismatches.",
             sb.timeouts, sb.withdrawals, sb.stores, sb.errors);
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
